// ===== design/ptrs_pkg.sv =====
// Shared types and constants for the periodic task ready scheduler.
// Holds the controller/datapath command and status structs and the codes.
// No dependencies; the design files refer to it by scoped names and the bench imports it.
package ptrs_pkg;

    // Table geometry and field widths
    localparam int TASK_SLOTS = 8;
    localparam int IDX_W      = $clog2(TASK_SLOTS);
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);
    localparam int FIELD_W    = 20;
    localparam int PRIO_W     = 8;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    localparam logic [FIELD_W-1:0] FIELD_MAX    = '1;
    localparam logic [FIELD_W-1:0] PERIOD_RESET = 20'd1000;
    localparam logic [PRIO_W-1:0]  PRIO_NEVER   = 8'hFF;

    // Item kinds; the fourth code is ignored
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK = 2'd0,
        KIND_REG  = 2'd1,
        KIND_DISP = 2'd2
    } t_kind;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Source of the result index
    typedef enum logic [1:0] {
        RS_ZERO = 2'd0,
        RS_IDX  = 2'd1,
        RS_SEL  = 2'd2
    } t_res_src;

    // Operand pair fed to the serial divider
    typedef enum logic {
        DS_RATE   = 1'b0,
        DS_PERIOD = 1'b1
    } t_div_src;

    // Controller to datapath
    typedef struct packed {
        logic     load;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_to_count;
        logic     div_start;
        t_div_src div_src;
        logic     tick_step;
        logic     scan_clr;
        logic     scan_step;
        logic     reg_write;
        logic     ready_clr_sel;
        logic     res_write;
        t_res_src res_src;
        t_status  res_status;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              count_zero;
        logic              full;
        logic              rate_zero;
        logic              last;
        logic              div_busy;
        logic              div_done;
        logic              found;
        logic              out_free;
    } t_sts;

endpackage

// ===== design/ptrs_if.sv =====
// Valid/ready channel interfaces for the scheduler's item input and result output.
// Depends on ptrs_pkg for field widths.
interface ptrs_in_if;
    logic                          valid;
    logic                          ready;
    logic [ptrs_pkg::KIND_W-1:0]   kind;
    logic [ptrs_pkg::PRIO_W-1:0]   task_priority;
    logic [ptrs_pkg::FIELD_W-1:0]  task_rate;

    modport source (output valid, output kind, output task_priority, output task_rate,
                    input ready);
    modport sink   (input valid, input kind, input task_priority, input task_rate,
                    output ready);
endinterface

interface ptrs_out_if;
    logic                          valid;
    logic                          ready;
    logic [ptrs_pkg::IDX_W-1:0]    task_index;
    logic [ptrs_pkg::STATUS_W-1:0] status;

    modport source (output valid, output task_index, output status, input ready);
    modport sink   (input valid, input task_index, input status, output ready);
endinterface

// ===== design/periodic_task_ready_scheduler_unit.sv =====
// Periodic task ready scheduler: up to eight periodic tasks, one result per item.
// A tick item and a dispatch item both walk the table one entry per cycle, over the N
// registered tasks; either item on an empty table answers without a walk. A register item
// runs two 20-step serial divides (base over frequency, then over the tick period), which
// are skipped for a zero frequency and for a full table. One item is in work at a time;
// the next is taken once the result sits in the output register, and the block stalls
// only if that register is still occupied. tick_period may be written while idle.
module periodic_task_ready_scheduler_unit #(
    parameter int unsigned RATE_BASE = 1000000
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ptrs_pkg::FIELD_W-1:0] i_cfg_wdata,
    ptrs_in_if.sink                      i_task,
    ptrs_out_if.source                   o_result
);
    ptrs_pkg::t_cmd w_cmd;
    ptrs_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_task.ready = w_in_ready;

    // Sequencing
    ptrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_task.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table, arithmetic and result registers
    ptrs_datapath #(
        .RATE_BASE (RATE_BASE)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_task.kind),
        .i_task_priority (i_task.task_priority),
        .i_task_rate     (i_task.task_rate),
        .o_out_valid     (o_result.valid),
        .i_out_ready     (o_result.ready),
        .o_task_index    (o_result.task_index),
        .o_status        (o_result.status)
    );

endmodule

// ===== design/ptrs_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on ptrs_pkg for the operand width.
module ptrs_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ptrs_pkg::FIELD_W-1:0] i_dividend,
    input  logic [ptrs_pkg::FIELD_W-1:0] i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [ptrs_pkg::FIELD_W-1:0] o_quotient
);
    localparam int W     = ptrs_pkg::FIELD_W;
    localparam int STEPW = $clog2(W);

    logic             r_busy, r_done;
    logic [STEPW-1:0] r_step;
    logic [W-1:0]     r_rem, r_quo, r_dvs;
    logic [W:0]       w_shift, w_dvs_ext;
    logic             w_ge;
    logic [W-1:0]     w_rem_next;

    // Shift in the next dividend bit and try the subtraction
    assign w_shift    = {r_rem, r_quo[W-1]};
    assign w_dvs_ext  = {1'b0, r_dvs};
    assign w_ge       = (w_shift >= w_dvs_ext);
    always_comb begin
        logic [W:0] diff;
        diff       = w_shift - w_dvs_ext;
        w_rem_next = w_ge ? diff[W-1:0] : w_shift[W-1:0];
    end

    // Control: step count, busy and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEPW'(1);
                if (r_step == STEPW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operands: the quotient register holds the dividend as it shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

endmodule

// ===== design/ptrs_datapath.sv =====
// Datapath of the scheduler: task table, tick and dispatch scan, divider and result registers.
// Depends on ptrs_pkg for the command/status structs and on ptrs_div.
module ptrs_datapath #(
    parameter int unsigned RATE_BASE = 1000000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptrs_pkg::t_cmd                i_cmd,
    output ptrs_pkg::t_sts                o_sts,
    input  logic                          i_cfg_we,
    input  logic [ptrs_pkg::FIELD_W-1:0]  i_cfg_wdata,
    input  logic [ptrs_pkg::KIND_W-1:0]   i_kind,
    input  logic [ptrs_pkg::PRIO_W-1:0]   i_task_priority,
    input  logic [ptrs_pkg::FIELD_W-1:0]  i_task_rate,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptrs_pkg::IDX_W-1:0]    o_task_index,
    output logic [ptrs_pkg::STATUS_W-1:0] o_status
);
    localparam int SLOTS = ptrs_pkg::TASK_SLOTS;
    localparam int IDX_W = ptrs_pkg::IDX_W;
    localparam int CNT_W = ptrs_pkg::CNT_W;
    localparam int FW    = ptrs_pkg::FIELD_W;
    localparam int PW    = ptrs_pkg::PRIO_W;
    localparam logic [FW-1:0] BASE = FW'(RATE_BASE);

    // Configuration and latched item
    logic [FW-1:0]              r_period;
    logic [ptrs_pkg::KIND_W-1:0] r_kind;
    logic [PW-1:0]              r_prio;
    logic [FW-1:0]              r_rate;

    // Task table
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [FW-1:0]    r_thr      [SLOTS];
    logic [FW-1:0]    r_cnt      [SLOTS];
    logic [PW-1:0]    r_prio_tab [SLOTS];
    logic [SLOTS-1:0] r_ready;

    // Dispatch scan
    logic [PW-1:0]    r_best;
    logic [IDX_W-1:0] r_sel;
    logic             r_found;

    // Staged and output result
    logic [IDX_W-1:0]              r_res_index;
    logic [ptrs_pkg::STATUS_W-1:0] r_res_status;
    logic                          r_out_valid;
    logic [IDX_W-1:0]              r_out_index;
    logic [ptrs_pkg::STATUS_W-1:0] r_out_status;

    // Divider
    logic [FW-1:0] w_div_dividend, w_div_divisor, w_quo;
    logic          w_div_busy, w_div_done;

    always_comb begin
        unique case (i_cmd.div_src)
            ptrs_pkg::DS_RATE: begin
                w_div_dividend = BASE;
                w_div_divisor  = r_rate;
            end
            ptrs_pkg::DS_PERIOD: begin
                w_div_dividend = w_quo;
                w_div_divisor  = (r_period == '0) ? FW'(1) : r_period;
            end
            default: begin
                w_div_dividend = BASE;
                w_div_divisor  = r_rate;
            end
        endcase
    end

    ptrs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    // Per-entry tick arithmetic at the current index
    logic [FW-1:0]    w_cnt_inc;
    logic             w_hit;
    logic [CNT_W-1:0] w_idx_next;
    logic [FW-1:0]    w_new_thr;

    assign w_cnt_inc  = (r_cnt[r_idx] != ptrs_pkg::FIELD_MAX) ? r_cnt[r_idx] + FW'(1)
                                                               : r_cnt[r_idx];
    assign w_hit      = (r_thr[r_idx] != ptrs_pkg::FIELD_MAX) && (w_cnt_inc >= r_thr[r_idx]);
    assign w_idx_next = CNT_W'(r_idx) + CNT_W'(1);
    assign w_new_thr  = (r_rate == '0) ? ptrs_pkg::FIELD_MAX : w_quo;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= ptrs_pkg::PERIOD_RESET;
        end else if (i_cfg_we) begin
            r_period <= i_cfg_wdata;
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_prio <= i_task_priority;
            r_rate <= i_task_rate;
        end
    end

    // Task count and walking index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.reg_write) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= w_idx_next[IDX_W-1:0];
            end else if (i_cmd.idx_to_count) begin
                r_idx <= r_count[IDX_W-1:0];
            end
        end
    end

    // Table entries: registration and tick update at the index
    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_write) begin
            r_thr[r_idx]      <= w_new_thr;
            r_cnt[r_idx]      <= '0;
            r_prio_tab[r_idx] <= r_prio;
        end else if (i_cmd.tick_step) begin
            r_cnt[r_idx] <= w_hit ? '0 : w_cnt_inc;
        end
    end

    // Ready flags: clear at registration, set on a hit, drop the dispatched one
    always_ff @(posedge i_clk) begin
        if (i_cmd.reg_write) begin
            r_ready[r_idx] <= 1'b0;
        end else if (i_cmd.tick_step && w_hit) begin
            r_ready[r_idx] <= 1'b1;
        end else if (i_cmd.ready_clr_sel) begin
            r_ready[r_sel] <= 1'b0;
        end
    end

    // Dispatch scan: keep the most urgent ready entry, first one on ties
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_best  <= ptrs_pkg::PRIO_NEVER;
            r_sel   <= '0;
        end else if (i_cmd.scan_clr) begin
            r_found <= 1'b0;
            r_best  <= ptrs_pkg::PRIO_NEVER;
            r_sel   <= '0;
        end else if (i_cmd.scan_step && r_ready[r_idx] && (r_prio_tab[r_idx] < r_best)) begin
            r_found <= 1'b1;
            r_best  <= r_prio_tab[r_idx];
            r_sel   <= r_idx;
        end
    end

    // Stage the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_write) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_src)
                ptrs_pkg::RS_IDX: r_res_index <= r_idx;
                ptrs_pkg::RS_SEL: r_res_index <= r_sel;
                default:          r_res_index <= '0;
            endcase
        end
    end

    // Output register: hold until the transaction is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_index  <= r_res_index;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_task_index = r_out_index;
    assign o_status     = r_out_status;

    // Status back to the controller
    assign o_sts.kind       = r_kind;
    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.full       = (r_count == CNT_W'(SLOTS));
    assign o_sts.rate_zero  = (r_rate == '0);
    assign o_sts.last       = (w_idx_next == r_count);
    assign o_sts.div_busy   = w_div_busy;
    assign o_sts.div_done   = w_div_done;
    assign o_sts.found      = r_found;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reg_write |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("registration did not advance the task count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("task count beyond table size");

    a_found_urgent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_best != ptrs_pkg::PRIO_NEVER)
        else $error("dispatch picked a never-run priority");

endmodule

// ===== design/ptrs_ctrl.sv =====
// Controller state machine of the scheduler: sequences register, tick and dispatch items.
// Depends on ptrs_pkg for the command/status structs and codes.
module ptrs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ptrs_pkg::t_sts i_sts,
    output ptrs_pkg::t_cmd o_cmd
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_DIV1  = 9'b000000100,
        S_DIV2  = 9'b000001000,
        S_WRITE = 9'b000010000,
        S_TICK  = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_PICK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state         r_state, n_state;
    ptrs_pkg::t_cmd w_cmd;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                unique case (i_sts.kind)
                    ptrs_pkg::KIND_TICK: begin
                        if (i_sts.count_zero) begin
                            w_cmd.res_write = 1'b1;
                            n_state         = S_DONE;
                        end else begin
                            w_cmd.idx_clr = 1'b1;
                            n_state       = S_TICK;
                        end
                    end
                    ptrs_pkg::KIND_REG: begin
                        if (i_sts.full) begin
                            w_cmd.res_write  = 1'b1;
                            w_cmd.res_status = ptrs_pkg::ST_FULL;
                            n_state          = S_DONE;
                        end else begin
                            w_cmd.idx_to_count = 1'b1;
                            if (i_sts.rate_zero) begin
                                n_state = S_WRITE;
                            end else begin
                                w_cmd.div_start = 1'b1;
                                w_cmd.div_src   = ptrs_pkg::DS_RATE;
                                n_state         = S_DIV1;
                            end
                        end
                    end
                    ptrs_pkg::KIND_DISP: begin
                        if (i_sts.count_zero) begin
                            w_cmd.res_write  = 1'b1;
                            w_cmd.res_status = ptrs_pkg::ST_EMPTY;
                            n_state          = S_DONE;
                        end else begin
                            w_cmd.idx_clr  = 1'b1;
                            w_cmd.scan_clr = 1'b1;
                            n_state        = S_SCAN;
                        end
                    end
                    default: begin
                        w_cmd.res_write = 1'b1;
                        n_state         = S_DONE;
                    end
                endcase
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    w_cmd.div_start = 1'b1;
                    w_cmd.div_src   = ptrs_pkg::DS_PERIOD;
                    n_state         = S_DIV2;
                end
            end
            S_DIV2: begin
                w_cmd.div_src = ptrs_pkg::DS_PERIOD;
                if (i_sts.div_done) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                w_cmd.reg_write = 1'b1;
                w_cmd.res_write = 1'b1;
                w_cmd.res_src   = ptrs_pkg::RS_IDX;
                n_state         = S_DONE;
            end
            S_TICK: begin
                w_cmd.tick_step = 1'b1;
                if (i_sts.last) begin
                    w_cmd.res_write = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                end
            end
            S_SCAN: begin
                w_cmd.scan_step = 1'b1;
                if (i_sts.last) begin
                    n_state = S_PICK;
                end else begin
                    w_cmd.idx_inc = 1'b1;
                end
            end
            S_PICK: begin
                w_cmd.res_write = 1'b1;
                if (i_sts.found) begin
                    w_cmd.ready_clr_sel = 1'b1;
                    w_cmd.res_src       = ptrs_pkg::RS_SEL;
                end else begin
                    w_cmd.res_status = ptrs_pkg::ST_EMPTY;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd = w_cmd;

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken transaction");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_sts.div_busy)
        else $error("divider restarted while busy");

endmodule

// ===== bench/periodic_task_ready_scheduler_unit_tb.sv =====
// Self-checking bench for the periodic task ready scheduler: a directed table, then random
// ticks, registrations, dispatches and unused kinds, checked against an in-bench schedule predictor.
// Depends on ptrs_pkg, ptrs_in_if, ptrs_out_if and the scheduler unit from the design folder.
module periodic_task_ready_scheduler_unit_tb;
    import ptrs_pkg::*;

    localparam int unsigned RATE_BASE      = 1000000;
    localparam int          QUIET_LIMIT    = 2000;
    localparam int          RANDOM_USEFUL  = 1100;
    localparam int          PHASE_ITEMS    = 100;
    localparam int          MAX_REPORTS    = 10;
    localparam int          DRAIN_CYCLES   = 60;
    localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PRIO_W-1:0]  task_priority;
        logic [FIELD_W-1:0] task_rate;
    } t_sched_item;

    typedef struct packed {
        logic [IDX_W-1:0] task_index;
        t_status          status;
    } t_sched_result;

    // One row of the directed table: a transaction or a tick_period write
    typedef enum logic { ROW_ITEM, ROW_PERIOD } t_row_op;

    typedef struct packed {
        t_row_op            op;
        logic [KIND_W-1:0]  kind;
        logic [PRIO_W-1:0]  prio;
        logic [FIELD_W-1:0] val;
        logic               typed;
        logic [IDX_W-1:0]   want_idx;
        t_status            want_st;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [FIELD_W-1:0] i_cfg_wdata;

    ptrs_in_if  in_if ();
    ptrs_out_if out_if ();

    periodic_task_ready_scheduler_unit #(
        .RATE_BASE (RATE_BASE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_task      (in_if.sink),
        .o_result    (out_if.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state: the task table as the block should hold it
    logic [FIELD_W-1:0] sched_period;
    int unsigned        slot_fill;
    logic [FIELD_W-1:0] slot_limit [TASK_SLOTS];
    logic [FIELD_W-1:0] slot_count [TASK_SLOTS];
    logic               slot_ready [TASK_SLOTS];
    logic [PRIO_W-1:0]  slot_prio  [TASK_SLOTS];

    t_sched_result awaited_outcomes [$];
    t_sched_result oldest;
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    bit            calm           = 1'b0;

    // Directed table: empty table, extremes of rate and priority, tick periods of 0, 1 and 1000000,
    // ties on priority, never-dispatched priority, full table
    t_plan_row directed_plan [25] = '{
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b1, 3'd0, ST_EMPTY},
        '{ROW_ITEM,   KIND_TICK, 8'h00, 20'd0,       1'b1, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_NOP,  8'hFF, 20'hFFFFF,   1'b1, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h00, 20'd1000,    1'b1, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'hFF, 20'hFFFFF,   1'b1, 3'd1, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h00, 20'd0,       1'b1, 3'd2, ST_OK},
        '{ROW_ITEM,   KIND_TICK, 8'h00, 20'd0,       1'b1, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_PERIOD, KIND_TICK, 8'h00, 20'd1,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h07, 20'd1000000, 1'b1, 3'd3, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h07, 20'd999999,  1'b1, 3'd4, ST_OK},
        '{ROW_ITEM,   KIND_TICK, 8'h00, 20'd0,       1'b1, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_PERIOD, KIND_TICK, 8'h00, 20'd1000000, 1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h80, 20'd1,       1'b1, 3'd5, ST_OK},
        '{ROW_PERIOD, KIND_TICK, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h03, 20'd200000,  1'b1, 3'd6, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'hFE, 20'd142857,  1'b1, 3'd7, ST_OK},
        '{ROW_ITEM,   KIND_REG,  8'h12, 20'd12345,   1'b1, 3'd0, ST_FULL},
        '{ROW_ITEM,   KIND_TICK, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK},
        '{ROW_ITEM,   KIND_DISP, 8'h00, 20'd0,       1'b0, 3'd0, ST_OK}
    };

    // Advance the predicted table by one transaction and return its result
    function automatic t_sched_result schedule_outcome(input t_sched_item it);
        t_sched_result      r;
        int unsigned        divisor;
        int unsigned        quot;
        int unsigned        best;
        logic [FIELD_W-1:0] next_count;
        bit                 hit;
        r.task_index = '0;
        r.status     = ST_OK;
        hit          = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                for (int i = 0; i < slot_fill; i++) begin
                    next_count = slot_count[i];
                    if (next_count != FIELD_MAX)
                        next_count = next_count + 1'b1;
                    // a never-ready slot only counts up and saturates
                    if (slot_limit[i] != FIELD_MAX && next_count >= slot_limit[i]) begin
                        next_count    = '0;
                        slot_ready[i] = 1'b1;
                    end
                    slot_count[i] = next_count;
                end
            end
            KIND_REG: begin
                if (slot_fill < TASK_SLOTS) begin
                    divisor = (sched_period == '0) ? 1 : sched_period;
                    if (it.task_rate == '0) begin
                        slot_limit[slot_fill] = FIELD_MAX;
                    end else begin
                        quot = (RATE_BASE / 32'(it.task_rate)) / divisor;
                        slot_limit[slot_fill] = (quot > FIELD_MAX) ? FIELD_MAX : quot[FIELD_W-1:0];
                    end
                    slot_count[slot_fill] = '0;
                    slot_ready[slot_fill] = 1'b0;
                    slot_prio[slot_fill]  = it.task_priority;
                    r.task_index          = IDX_W'(slot_fill);
                    slot_fill++;
                end else begin
                    r.status = ST_FULL;
                end
            end
            KIND_DISP: begin
                best = PRIO_NEVER;
                for (int i = 0; i < slot_fill; i++) begin
                    if (slot_ready[i] && slot_prio[i] < best) begin
                        best         = slot_prio[i];
                        r.task_index = IDX_W'(i);
                        hit          = 1'b1;
                    end
                end
                if (hit) begin
                    slot_ready[r.task_index] = 1'b0;
                end else begin
                    r.task_index = '0;
                    r.status     = ST_EMPTY;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit want_pause();
        return !calm && ($urandom_range(99) < 7);
    endfunction

    function automatic void flag_mismatch(input string what, input logic [7:0] want,
                                          input logic [7:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Offer one transaction, hold it until taken, then log its expected result
    task automatic issue_item(input t_sched_item it, input bit typed,
                              input t_sched_result want);
        t_sched_result predicted;
        @(negedge i_clk);
        while (want_pause()) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.kind          <= it.kind;
        in_if.task_priority <= it.task_priority;
        in_if.task_rate     <= it.task_rate;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predicted = schedule_outcome(it);
        awaited_outcomes.push_back(typed ? want : predicted);
    endtask

    // Drain the block, then write tick_period while it sits idle
    task automatic write_period(input logic [FIELD_W-1:0] value);
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sched_period = value;
    endtask

    // Result side: stall at random, except in calm stretches
    always @(negedge i_clk)
        out_if.ready <= !want_pause();

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
                flag_mismatch("unexpected result", 8'h00,
                              {3'b000, out_if.task_index, out_if.status});
            end else begin
                oldest = awaited_outcomes.pop_front();
                if (out_if.task_index !== oldest.task_index)
                    flag_mismatch("task_index", 8'(oldest.task_index), 8'(out_if.task_index));
                if (out_if.status !== oldest.status)
                    flag_mismatch("status", 8'(oldest.status), 8'(out_if.status));
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge i_clk) begin
        if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_sched_item   it;
        t_sched_result want;
        int            useful;
        int            phase_end;
        int            pick;
        logic [FIELD_W-1:0] period_pick;

        // Hold every input at a known value, predictor at its reset state
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_wdata         = '0;
        in_if.valid         = 1'b0;
        in_if.kind          = '0;
        in_if.task_priority = '0;
        in_if.task_rate     = '0;
        out_if.ready        = 1'b0;
        sched_period        = PERIOD_RESET;
        slot_fill           = 0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_limit[i] = '0;
            slot_count[i] = '0;
            slot_ready[i] = 1'b0;
            slot_prio[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_plan[r]) begin
            if (directed_plan[r].op == ROW_PERIOD) begin
                write_period(directed_plan[r].val);
            end else begin
                it.kind          = directed_plan[r].kind;
                it.task_priority = directed_plan[r].prio;
                it.task_rate     = directed_plan[r].val;
                want.task_index  = directed_plan[r].want_idx;
                want.status      = directed_plan[r].want_st;
                issue_item(it, directed_plan[r].typed, want);
            end
        end

        // Random phases: mostly ticks and dispatches, some full-table registrations and noise
        useful = 0;
        want   = '0;
        for (int phase = 0; useful < RANDOM_USEFUL; phase++) begin
            case (phase % 4)
                0:       period_pick = 20'd1;
                1:       period_pick = 20'd1000000;
                2:       period_pick = PERIOD_RESET;
                default: period_pick = FIELD_W'($urandom_range(1, 1000000));
            endcase
            write_period(period_pick);
            calm      = (phase == 5 || phase == 6);
            phase_end = useful + PHASE_ITEMS;
            while (useful < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    it.kind = KIND_TICK;
                else if (pick < 85)
                    it.kind = KIND_DISP;
                else if (pick < 93)
                    it.kind = KIND_REG;
                else
                    it.kind = KIND_NOP;
                it.task_priority = PRIO_W'($urandom_range(0, 255));
                it.task_rate     = FIELD_W'($urandom_range(0, FIELD_MAX));
                issue_item(it, 1'b0, want);
                useful++;
            end
        end
        calm = 1'b0;

        // Drop valid, drain the expected results, then idle before the verdict
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
